[hdl/quicksort_buffer_sorter_defines.svh]
// assertion macros for the quicksort buffer sorter
`ifndef QUICKSORT_BUFFER_SORTER_DEFINES_SVH
`define QUICKSORT_BUFFER_SORTER_DEFINES_SVH

`ifndef SYNTH
`define QSBS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("qsbs assertion failed");
`define QSBS_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("qsbs forbidden condition seen");
`else
`define QSBS_ASSERT(name, clk, rst_n, prop)
`define QSBS_NEVER(name, clk, rst_n, cond)
`endif

`endif

[hdl/qsbs_pkg.sv]
// shared types, constants and datapath operation codes for the quicksort buffer sorter
package qsbs_pkg;

  localparam int unsigned MAX_ELEMENTS = 64;
  localparam int unsigned DATA_W       = 32;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_res;
    logic                     overflow;
  } res_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT,
    OP_POP,
    OP_PIVOT,
    OP_RDK,
    OP_RDMARK,
    OP_SWAP0,
    OP_ADV_BOTH,
    OP_ADV_K,
    OP_SW1,
    OP_SW2,
    OP_FIN1,
    OP_FIN2,
    OP_PUSH1,
    OP_PUSH2,
    OP_EMIT_INIT,
    OP_EMIT
  } op_e;

  typedef struct packed {
    logic cnt_lt2;
    logic stack_empty;
    logic k_eq_hi;
    logic k_eq_mark;
    logic le;
    logic emit_last;
  } status_t;

endpackage

[hdl/qsbs_datapath.sv]
// datapath: element memory, range stack, partition indices and result register
module qsbs_datapath #(
  parameter int unsigned MaxElements = qsbs_pkg::MAX_ELEMENTS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  qsbs_pkg::op_e      op_i,
  input  qsbs_pkg::req_t     req_i,
  output qsbs_pkg::status_t  status_o,
  output logic               res_valid_o,
  output qsbs_pkg::res_t     res_o
);

  localparam int unsigned IdxW       = $clog2(MaxElements);
  localparam int unsigned CntW       = $clog2(MaxElements + 1);
  localparam int unsigned StackDepth = IdxW + 2;
  localparam int unsigned SpW        = $clog2(StackDepth + 1);
  localparam int unsigned SpIdxW     = $clog2(StackDepth);
  localparam int unsigned DataW      = qsbs_pkg::DATA_W;

  typedef struct packed {
    logic [IdxW-1:0] lo;
    logic [IdxW-1:0] hi;
  } range_t;

  logic [DataW-1:0]        store_q [MaxElements];
  range_t                  stack_q [StackDepth];

  logic [CntW-1:0]         count_q, count_d;
  logic                    dropped_q, dropped_d;
  logic [SpW-1:0]          sp_q, sp_d;
  logic                    res_valid_q;
  qsbs_pkg::res_t          res_q;

  logic [IdxW-1:0]         lo_q, hi_q, k_q, mark_q;
  logic signed [DataW-1:0] pivot_q, hold_q, rdata_q;

  logic [SpW-1:0]          sp_m1;
  range_t                  top;
  logic [IdxW-1:0]         raddr;
  logic                    we;
  logic [IdxW-1:0]         waddr;
  logic [DataW-1:0]        wdata;
  logic                    room;
  range_t                  left_rng, right_rng, push_rng;
  logic                    left_ok, right_ok, left_ge, push_ok, push_en;
  logic                    emit_last;

  assign sp_m1 = sp_q - SpW'(1);
  assign top   = stack_q[sp_m1[SpIdxW-1:0]];
  assign room  = (count_q < CntW'(MaxElements));

  // subranges around the final pivot slot
  assign left_rng  = '{lo: lo_q, hi: mark_q - IdxW'(1)};
  assign right_rng = '{lo: mark_q + IdxW'(1), hi: hi_q};
  assign left_ok   = ({1'b0, mark_q} > ({1'b0, lo_q} + (IdxW+1)'(1)));
  assign right_ok  = (({1'b0, mark_q} + (IdxW+1)'(1)) < {1'b0, hi_q});
  assign left_ge   = ((mark_q - lo_q) >= (hi_q - mark_q));
  assign emit_last = ((CntW'(k_q) + CntW'(1)) == count_q);

  // larger subrange goes on the stack first
  always_comb begin
    push_rng = left_rng;
    push_ok  = 1'b0;
    case (op_i)
      qsbs_pkg::OP_INIT: begin
        push_rng = '{lo: '0, hi: IdxW'(count_q - CntW'(1))};
        push_ok  = 1'b1;
      end
      qsbs_pkg::OP_PUSH1: begin
        push_rng = left_ge ? left_rng : right_rng;
        push_ok  = left_ge ? left_ok : right_ok;
      end
      qsbs_pkg::OP_PUSH2: begin
        push_rng = left_ge ? right_rng : left_rng;
        push_ok  = left_ge ? right_ok : left_ok;
      end
      default: begin
        push_rng = left_rng;
        push_ok  = 1'b0;
      end
    endcase
  end

  assign push_en = push_ok && (sp_q < SpW'(StackDepth));

  always_comb begin
    raddr = k_q;
    we    = 1'b0;
    waddr = k_q;
    wdata = rdata_q;
    case (op_i)
      qsbs_pkg::OP_LOAD: begin
        we    = room;
        waddr = count_q[IdxW-1:0];
        wdata = req_i.value;
      end
      qsbs_pkg::OP_POP:    raddr = top.hi;
      qsbs_pkg::OP_RDMARK: raddr = mark_q;
      qsbs_pkg::OP_SWAP0:  raddr = mark_q;
      qsbs_pkg::OP_SW1: begin
        we    = 1'b1;
        waddr = k_q;
        wdata = rdata_q;
      end
      qsbs_pkg::OP_SW2: begin
        we    = 1'b1;
        waddr = mark_q;
        wdata = hold_q;
      end
      qsbs_pkg::OP_FIN1: begin
        we    = 1'b1;
        waddr = hi_q;
        wdata = rdata_q;
      end
      qsbs_pkg::OP_FIN2: begin
        we    = 1'b1;
        waddr = mark_q;
        wdata = pivot_q;
      end
      default: raddr = k_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      store_q[waddr] <= wdata;
    end
    rdata_q <= store_q[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (push_en) begin
      stack_q[sp_q[SpIdxW-1:0]] <= push_rng;
    end
  end

  always_comb begin
    count_d   = count_q;
    dropped_d = dropped_q;
    sp_d      = sp_q;
    case (op_i)
      qsbs_pkg::OP_LOAD: begin
        if (room) begin
          count_d = count_q + CntW'(1);
        end else begin
          dropped_d = 1'b1;
        end
      end
      qsbs_pkg::OP_INIT: sp_d = SpW'(1);
      qsbs_pkg::OP_POP:  sp_d = sp_m1;
      qsbs_pkg::OP_PUSH1,
      qsbs_pkg::OP_PUSH2: begin
        if (push_en) begin
          sp_d = sp_q + SpW'(1);
        end
      end
      qsbs_pkg::OP_EMIT: begin
        if (emit_last) begin
          count_d   = '0;
          dropped_d = 1'b0;
        end
      end
      default: sp_d = sp_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      dropped_q   <= 1'b0;
      sp_q        <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      dropped_q   <= dropped_d;
      sp_q        <= sp_d;
      res_valid_q <= (op_i == qsbs_pkg::OP_EMIT);
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      qsbs_pkg::OP_POP: begin
        lo_q <= top.lo;
        hi_q <= top.hi;
      end
      qsbs_pkg::OP_PIVOT: begin
        pivot_q <= rdata_q;
        k_q     <= lo_q;
        mark_q  <= lo_q;
      end
      qsbs_pkg::OP_SWAP0: hold_q <= rdata_q;
      qsbs_pkg::OP_ADV_BOTH,
      qsbs_pkg::OP_SW2: begin
        k_q    <= k_q + IdxW'(1);
        mark_q <= mark_q + IdxW'(1);
      end
      qsbs_pkg::OP_ADV_K:    k_q <= k_q + IdxW'(1);
      qsbs_pkg::OP_EMIT_INIT: k_q <= '0;
      qsbs_pkg::OP_EMIT: begin
        k_q                <= k_q + IdxW'(1);
        res_q.sorted_value <= rdata_q;
        res_q.last_res     <= emit_last;
        res_q.overflow     <= dropped_q;
      end
      default: k_q <= k_q;
    endcase
  end

  assign status_o.cnt_lt2     = (count_q < CntW'(2));
  assign status_o.stack_empty = (sp_q == '0);
  assign status_o.k_eq_hi     = (k_q == hi_q);
  assign status_o.k_eq_mark   = (k_q == mark_q);
  assign status_o.le          = (rdata_q <= pivot_q);
  assign status_o.emit_last   = emit_last;

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

[hdl/qsbs_ctrl.sv]
// controller: sequences loading, lomuto partitioning, range stack handling and output
module qsbs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              last_i,
  input  qsbs_pkg::status_t status_i,
  output qsbs_pkg::op_e     op_o,
  output logic              busy_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BEGIN,
    ST_POP,
    ST_PIV,
    ST_RDK,
    ST_CMP,
    ST_SW1,
    ST_SW2,
    ST_FIN1,
    ST_FIN2,
    ST_PUSH1,
    ST_PUSH2,
    ST_EMIT_INIT,
    ST_ERD,
    ST_EOUT
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  always_comb begin
    state_d = state_q;
    op_o    = qsbs_pkg::OP_NONE;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_o = qsbs_pkg::OP_LOAD;
          if (last_i) begin
            state_d = ST_BEGIN;
          end
        end
      end
      ST_BEGIN: begin
        if (status_i.cnt_lt2) begin
          state_d = ST_EMIT_INIT;
        end else begin
          op_o    = qsbs_pkg::OP_INIT;
          state_d = ST_POP;
        end
      end
      ST_POP: begin
        if (status_i.stack_empty) begin
          state_d = ST_EMIT_INIT;
        end else begin
          op_o    = qsbs_pkg::OP_POP;
          state_d = ST_PIV;
        end
      end
      ST_PIV: begin
        op_o    = qsbs_pkg::OP_PIVOT;
        state_d = ST_RDK;
      end
      ST_RDK: begin
        // scan done: fetch the element at the mark for the final exchange
        if (status_i.k_eq_hi) begin
          op_o    = qsbs_pkg::OP_RDMARK;
          state_d = ST_FIN1;
        end else begin
          op_o    = qsbs_pkg::OP_RDK;
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        if (status_i.le && !status_i.k_eq_mark) begin
          op_o    = qsbs_pkg::OP_SWAP0;
          state_d = ST_SW1;
        end else if (status_i.le) begin
          op_o    = qsbs_pkg::OP_ADV_BOTH;
          state_d = ST_RDK;
        end else begin
          op_o    = qsbs_pkg::OP_ADV_K;
          state_d = ST_RDK;
        end
      end
      ST_SW1: begin
        op_o    = qsbs_pkg::OP_SW1;
        state_d = ST_SW2;
      end
      ST_SW2: begin
        op_o    = qsbs_pkg::OP_SW2;
        state_d = ST_RDK;
      end
      ST_FIN1: begin
        op_o    = qsbs_pkg::OP_FIN1;
        state_d = ST_FIN2;
      end
      ST_FIN2: begin
        op_o    = qsbs_pkg::OP_FIN2;
        state_d = ST_PUSH1;
      end
      ST_PUSH1: begin
        op_o    = qsbs_pkg::OP_PUSH1;
        state_d = ST_PUSH2;
      end
      ST_PUSH2: begin
        op_o    = qsbs_pkg::OP_PUSH2;
        state_d = ST_POP;
      end
      ST_EMIT_INIT: begin
        op_o    = qsbs_pkg::OP_EMIT_INIT;
        state_d = ST_ERD;
      end
      ST_ERD: begin
        op_o    = qsbs_pkg::OP_RDK;
        state_d = ST_EOUT;
      end
      ST_EOUT: begin
        op_o    = qsbs_pkg::OP_EMIT;
        state_d = status_i.emit_last ? ST_IDLE : ST_ERD;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != ST_IDLE);
    end
  end

  assign busy_o = busy_q;

endmodule

[hdl/quicksort_buffer_sorter.sv]
// top level of the quicksort buffer sorter: controller plus datapath
// Loads one signed 32-bit value per request (start_i high while busy_o is low) into a buffer of
// MaxElements entries (2 to 64); values past capacity are dropped and every result of that set
// carries overflow. The request marked last raises busy_o and starts an in-place quicksort
// (Lomuto partition, last element as pivot, range stack in registers). All work goes through the
// single read / single write port of the element memory: each partition step reads and compares
// one element, and a step that swaps adds an exchange through the mark; each range adds a pop,
// a pivot read, the final exchange and the pushes of its subranges. The N results then follow as
// one-cycle strobes on res_valid_o, the final one flagged by last_res; the receiver cannot stall
// them. busy_o drops in the cycle the final result is shown, and the next request may be taken
// from then on.
`include "quicksort_buffer_sorter_defines.svh"

module quicksort_buffer_sorter #(
  parameter int unsigned MaxElements = qsbs_pkg::MAX_ELEMENTS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  qsbs_pkg::req_t req_i,
  output logic           res_valid_o,
  output qsbs_pkg::res_t res_o
);

  qsbs_pkg::op_e     op;
  qsbs_pkg::status_t status;

  qsbs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .last_i   (req_i.last),
    .status_i (status),
    .op_o     (op),
    .busy_o   (busy_o)
  );

  qsbs_datapath #(
    .MaxElements (MaxElements)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .req_i       (req_i),
    .status_o    (status),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // results only come out of a sort that was running
  `QSBS_ASSERT(a_res_after_busy, clk_i, rst_ni, res_valid_o |-> $past(busy_o))
  // the block goes idle exactly with the final result of the set
  `QSBS_ASSERT(a_idle_on_last, clk_i, rst_ni, $fell(busy_o) |-> (res_valid_o && res_o.last_res))
  // more results pending keeps the block busy
  `QSBS_NEVER(a_gap_after_mid, clk_i, rst_ni, $past(res_valid_o && !res_o.last_res) && !busy_o)

endmodule

[tb/sv/tb.sv]
// self-checking testbench for the quicksort buffer sorter
`timescale 1ns / 100ps

module tb;

  localparam int LIMIT_CYCLES = 600000;
  localparam int DIR_ROWS     = 22;
  localparam int RAND_ITEMS   = 400;
  localparam logic signed [qsbs_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [qsbs_pkg::DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic signed [qsbs_pkg::DATA_W-1:0] val;
    bit                                 lst;
    bit                                 typed;
  } stim_row_t;

  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           start_i;
  logic           busy_o;
  qsbs_pkg::req_t req_i;
  logic           res_valid_o;
  qsbs_pkg::res_t res_o;

  // predictor state: elements of the set being loaded, its drop flag and the expected results
  logic signed [qsbs_pkg::DATA_W-1:0] held_vals[$];
  bit                                 drop_seen;
  qsbs_pkg::res_t                     sorted_due[$];
  qsbs_pkg::res_t                     due_head;

  int idle_pct;
  int fail_cnt;
  int cycle_cnt;
  int req_cnt;
  int set_cnt;
  int checked_cnt;
  int overflow_sets;
  int largest_set;

  quicksort_buffer_sorter i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("quicksort_buffer_sorter verification failed");
      $finish;
    end
  end

  // store one element, and on the final one queue the whole set in ascending order
  task automatic absorb_element(input qsbs_pkg::req_t r, input bit typed);
    logic signed [qsbs_pkg::DATA_W-1:0] key;
    int j;
    int n;
    if (held_vals.size() < qsbs_pkg::MAX_ELEMENTS) held_vals.push_back(r.value);
    else drop_seen = 1'b1;
    if (r.last) begin
      n = held_vals.size();
      for (int i = 1; i < n; i++) begin
        key = held_vals[i];
        j = i - 1;
        while (j >= 0 && held_vals[j] > key) begin
          held_vals[j + 1] = held_vals[j];
          j--;
        end
        held_vals[j + 1] = key;
      end
      if (typed) begin
        // single-element set with the result written into the table
        sorted_due.push_back('{sorted_value: r.value, last_res: 1'b1, overflow: 1'b0});
      end else begin
        for (int k = 0; k < n; k++)
          sorted_due.push_back('{sorted_value: held_vals[k], last_res: (k == n - 1),
                                 overflow: drop_seen});
      end
      set_cnt++;
      if (drop_seen) overflow_sets++;
      if (n > largest_set) largest_set = n;
      held_vals.delete();
      drop_seen = 1'b0;
    end
  endtask

  // called at a falling edge, returns at the falling edge after the request is taken
  task automatic send_request(input qsbs_pkg::req_t r, input bit typed);
    bit taken;
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= r;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !busy_o;
    end
    absorb_element(r, typed);
    req_cnt++;
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (sorted_due.size() == 0) begin
        $error("result with nothing pending: sorted_value %0d", res_o.sorted_value);
        fail_cnt++;
      end else begin
        due_head = sorted_due.pop_front();
        checked_cnt++;
        if (res_o.sorted_value !== due_head.sorted_value) begin
          $error("sorted_value: expected %0d, got %0d", due_head.sorted_value,
                 res_o.sorted_value);
          fail_cnt++;
        end
        if (res_o.last_res !== due_head.last_res) begin
          $error("last_res: expected %0b, got %0b", due_head.last_res, res_o.last_res);
          fail_cnt++;
        end
        if (res_o.overflow !== due_head.overflow) begin
          $error("overflow: expected %0b, got %0b", due_head.overflow, res_o.overflow);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    stim_row_t                          dir_tab [DIR_ROWS];
    int                                 pct_tab [3];
    qsbs_pkg::req_t                     r;
    int                                 set_size;
    int                                 pattern;
    int                                 step;
    int                                 rand_sent;
    int                                 set_idx;
    logic signed [qsbs_pkg::DATA_W-1:0] base;
    logic signed [qsbs_pkg::DATA_W-1:0] v;

    dir_tab = '{
      '{VAL_MIN, 1'b1, 1'b1},
      '{VAL_MAX, 1'b1, 1'b1},
      '{-32'sd1, 1'b1, 1'b1},
      '{32'sd0, 1'b1, 1'b1},
      // duplicates mixed with both extremes
      '{32'sd7, 1'b0, 1'b0},
      '{VAL_MIN, 1'b0, 1'b0},
      '{32'sd7, 1'b0, 1'b0},
      '{VAL_MAX, 1'b0, 1'b0},
      '{-32'sd3, 1'b1, 1'b0},
      // already ascending, worst case for the last-element pivot
      '{32'sd1, 1'b0, 1'b0},
      '{32'sd2, 1'b0, 1'b0},
      '{32'sd3, 1'b0, 1'b0},
      '{32'sd4, 1'b0, 1'b0},
      '{32'sd5, 1'b1, 1'b0},
      '{32'sd5, 1'b0, 1'b0},
      '{32'sd4, 1'b0, 1'b0},
      '{32'sd3, 1'b0, 1'b0},
      '{32'sd2, 1'b0, 1'b0},
      '{32'sd1, 1'b1, 1'b0},
      '{32'shaaaa_aaaa, 1'b0, 1'b0},
      '{32'sh5555_5555, 1'b0, 1'b0},
      '{32'sd0, 1'b1, 1'b0}
    };
    pct_tab = '{0, 45, 12};

    start_i = 1'b0;
    req_i   = '0;
    rst_ni  = 1'b0;
    drop_seen = 1'b0;
    idle_pct  = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      idle_pct = (i < DIR_ROWS / 2) ? 0 : 45;
      r.value = dir_tab[i].val;
      r.last  = dir_tab[i].lst;
      send_request(r, dir_tab[i].typed);
    end

    rand_sent = 0;
    set_idx   = 0;
    while (rand_sent < RAND_ITEMS) begin
      idle_pct = pct_tab[(set_idx / 6) % 3];
      case ($urandom_range(0, 99)) inside
        [0:69]:  set_size = $urandom_range(1, 12);
        [70:84]: set_size = $urandom_range(13, 40);
        [85:91]: set_size = qsbs_pkg::MAX_ELEMENTS;
        // last request lands just past capacity and is dropped
        [92:95]: set_size = qsbs_pkg::MAX_ELEMENTS + 1;
        default: set_size = $urandom_range(qsbs_pkg::MAX_ELEMENTS + 2,
                                           qsbs_pkg::MAX_ELEMENTS + 6);
      endcase
      pattern = $urandom_range(0, 4);
      base = $signed($urandom_range(0, 2000)) - 1000;
      step = $urandom_range(0, 3);
      for (int k = 0; k < set_size; k++) begin
        case (pattern)
          0: v = $urandom;
          1: v = $signed($urandom_range(0, 7)) - 4;
          2: v = base + k * step;
          3: v = base - k * step;
          default: begin
            case ($urandom_range(0, 4))
              0: v = VAL_MIN;
              1: v = VAL_MAX;
              2: v = '0;
              3: v = '1;
              default: v = $urandom;
            endcase
          end
        endcase
        r.value = v;
        r.last  = (k == set_size - 1);
        send_request(r, 1'b0);
        rand_sent++;
      end
      set_idx++;
    end
    start_i <= 1'b0;

    while (sorted_due.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("%0d requests in %0d sets (largest %0d), %0d with dropped elements",
             req_cnt, set_cnt, largest_set, overflow_sets);
    $display("%0d sorted results compared in %0d cycles", checked_cnt, cycle_cnt);
    if (fail_cnt == 0) begin
      $display("quicksort_buffer_sorter verification clean");
    end else begin
      $display("quicksort_buffer_sorter verification failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/qsbs_pkg.sv
hdl/qsbs_datapath.sv
hdl/qsbs_ctrl.sv
hdl/quicksort_buffer_sorter.sv
tb/sv/tb.sv
